// ===== hw/rtl/lpm_pkg.sv =====
package lpm_pkg;

    // address and table sizing
    localparam int ADDR_BITS           = 32;
    localparam int PLEN_BITS           = 6;
    localparam int FIELD_TAG_BITS      = 16;
    localparam int DEFAULT_TABLE_DEPTH = 128;
    localparam int DEFAULT_TAG_BITS    = 16;
    localparam logic [ADDR_BITS-1:0] ALL_ONES = '1;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ROUTED   = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    // request item
    typedef struct packed {
        logic                      command;
        logic [ADDR_BITS-1:0]      address;
        logic [PLEN_BITS-1:0]      prefix_length;
        logic [FIELD_TAG_BITS-1:0] peer_tag;
    } lpm_in_t;

    // result item
    typedef struct packed {
        logic [1:0]                status;
        logic [FIELD_TAG_BITS-1:0] matched_tag;
        logic [PLEN_BITS-1:0]      matched_prefix;
    } lpm_out_t;

    // one route as read back from the table
    typedef struct packed {
        logic [ADDR_BITS-1:0]      network;
        logic [PLEN_BITS-1:0]      prefix;
        logic [FIELD_TAG_BITS-1:0] tag;
    } lpm_entry_t;

    // control of the match unit
    typedef struct packed {
        logic clear;
        logic valid;
    } lpm_match_ctrl_t;

    // best route so far
    typedef struct packed {
        logic                      found;
        logic [PLEN_BITS-1:0]      prefix;
        logic [FIELD_TAG_BITS-1:0] tag;
    } lpm_best_t;

    // clamp a prefix length to the address width
    function automatic logic [PLEN_BITS-1:0] sat_prefix(input logic [PLEN_BITS-1:0] plen);
        logic [PLEN_BITS-1:0] res;
        if (plen > PLEN_BITS'(ADDR_BITS))
            res = PLEN_BITS'(ADDR_BITS);
        else
            res = plen;
        return res;
    endfunction

    // leading-ones mask; zero length gives an empty mask
    function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [PLEN_BITS-1:0] plen);
        logic [PLEN_BITS-1:0] p;
        logic [ADDR_BITS-1:0] res;
        p = sat_prefix(plen);
        if (p == '0)
            res = '0;
        else
            res = ALL_ONES << (PLEN_BITS'(ADDR_BITS) - p);
        return res;
    endfunction

endpackage

// ===== hw/rtl/ipv4_longest_prefix_match_table.sv =====
// insert: result strobed on done in the cycle after the item is accepted; busy stays low
// lookup: result strobed after the scan and last states (empty table: the cycle after
//   acceptance); the scan reads one stored route per cycle from the table ram port
// a new item is taken in the cycle its predecessor's result is shown; done is a
//   one-cycle strobe and the receiver cannot stall it
// reset clears the route count and control; the table ram itself is never cleared
module ipv4_longest_prefix_match_table
    import lpm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int TAG_BITS    = DEFAULT_TAG_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  lpm_in_t  request,
    output logic     done,
    output lpm_out_t result
);

    localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW      = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = ADDR_BITS + PLEN_BITS + TAG_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic                 rvalid_reg;
    logic [ADDR_BITS-1:0] key_reg;
    logic                 done_reg;
    lpm_out_t             result_reg;

    logic                 accept;
    logic                 full;
    logic                 last_issue;
    logic                 wr_en;
    logic                 rd_en;
    logic [PLEN_BITS-1:0] plen_sat;
    logic [TAG_BITS+FIELD_TAG_BITS-1:0] tag_in_ext;
    logic [TAG_BITS+FIELD_TAG_BITS-1:0] tag_out_ext;
    logic [ENTRY_W-1:0]   wdata;
    logic [ENTRY_W-1:0]   rdata;
    lpm_entry_t           entry;
    lpm_match_ctrl_t      mctrl;
    lpm_best_t            best_next;

    assign accept     = start && !busy;
    assign full       = (count_reg == CW'(TABLE_DEPTH));
    assign last_issue = (CW'(rd_idx_reg) == (count_reg - CW'(1)));

    // inserts write at the accept edge; lookups only read after it, so no overlap
    assign wr_en      = accept && (request.command == CMD_INSERT) && !full;
    assign rd_en      = (state_reg == S_SCAN);
    assign plen_sat   = sat_prefix(request.prefix_length);
    assign tag_in_ext = {{TAG_BITS{1'b0}}, request.peer_tag};
    assign wdata      = {request.address & prefix_mask(plen_sat), plen_sat,
                         tag_in_ext[TAG_BITS-1:0]};

    lpm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (wr_en),
        .waddr(count_reg[AW-1:0]),
        .wdata(wdata),
        .re   (rd_en),
        .raddr(rd_idx_reg),
        .rdata(rdata)
    );

    // unpack the read route
    assign tag_out_ext   = {{FIELD_TAG_BITS{1'b0}}, rdata[TAG_BITS-1:0]};
    assign entry.network = rdata[ENTRY_W-1 -: ADDR_BITS];
    assign entry.prefix  = rdata[TAG_BITS +: PLEN_BITS];
    assign entry.tag     = tag_out_ext[FIELD_TAG_BITS-1:0];

    assign mctrl.clear = accept && (request.command == CMD_LOOKUP);
    assign mctrl.valid = rvalid_reg;

    lpm_match u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mctrl),
        .key      (key_reg),
        .entry    (entry),
        .best_next(best_next)
    );

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg   <= 1'b0;
            rvalid_reg <= rd_en;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (request.command == CMD_INSERT)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: (full ? ST_FULL : ST_INSERTED),
                                            matched_tag: '0, matched_prefix: '0};
                            if (!full)
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: ST_DROPPED,
                                            matched_tag: '0, matched_prefix: '0};
                        end
                        else
                        begin
                            rd_idx_reg <= '0;
                            state_reg  <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (last_issue)
                    begin
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + AW'(1);
                    end
                end
                S_LAST:
                begin
                    // last route is compared this cycle
                    done_reg <= 1'b1;
                    if (best_next.found)
                    begin
                        result_reg <= '{status: ST_ROUTED, matched_tag: best_next.tag,
                                        matched_prefix: best_next.prefix};
                    end
                    else
                    begin
                        result_reg <= '{status: ST_DROPPED,
                                        matched_tag: '0, matched_prefix: '0};
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // destination held for the scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= request.address;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/lpm_ram.sv =====
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/lpm_match.sv =====
module lpm_match
    import lpm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  lpm_match_ctrl_t ctrl,
    input  logic [ADDR_BITS-1:0] key,
    input  lpm_entry_t      entry,
    output lpm_best_t       best_next
);

    lpm_best_t best_reg;
    logic      hit;
    logic      take;

    // compare one route against the destination
    assign hit  = ((key & prefix_mask(entry.prefix)) == entry.network);
    assign take = ctrl.valid && hit && (!best_reg.found || (entry.prefix > best_reg.prefix));

    // strictly longer prefix replaces, so the earliest of equals stays
    always_comb
    begin
        best_next = best_reg;
        if (ctrl.clear)
        begin
            best_next = '0;
        end
        else if (take)
        begin
            best_next.found  = 1'b1;
            best_next.prefix = entry.prefix;
            best_next.tag    = entry.tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

endmodule

// ===== hw/rtl/lpm_checker.sv =====
module lpm_checker
    import lpm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input lpm_in_t  request,
    input logic     done,
    input lpm_out_t result
);

    // an accepted insert answers in the next cycle with an insert status
    a_insert_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.command == CMD_INSERT) |=>
            done && ((result.status == ST_INSERTED) || (result.status == ST_FULL)))
        else $error("insert item not answered in the next cycle");

    // a result only follows an accepted item or a running scan
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy) || $past(busy))
        else $error("result strobe without a pending item");

    // the end of a scan always delivers its result
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done && ((result.status == ST_ROUTED) || (result.status == ST_DROPPED)))
        else $error("scan ended without a lookup result");

    // non-routed results carry zero tag and prefix
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != ST_ROUTED) |->
            (result.matched_tag == '0) && (result.matched_prefix == '0))
        else $error("non-routed result with nonzero fields");

    // a routed prefix never exceeds the address width
    a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_ROUTED) |-> result.matched_prefix <= PLEN_BITS'(ADDR_BITS))
        else $error("routed prefix out of range");

endmodule

bind ipv4_longest_prefix_match_table lpm_checker u_lpm_checker (.*);
